// ===== sv/lcdlt_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD line timing package
// Shared types for the line timing and status block: channel payloads,
// display mode codes and the timing state.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdlt_pkg;

	localparam int CNT_W  = 10;
	localparam int LINE_W = 8;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [7:0] cycles;
		logic       lcd_enable;
		logic [7:0] lyc;
		logic       int_en_hblank;
		logic       int_en_vblank;
		logic       int_en_oam;
		logic       int_en_lyc;
	} in_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] line;
		logic       lyc_match;
		logic       stat_irq;
		logic       vblank_irq;
		logic       render_req;
		logic [7:0] render_line;
	} out_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] cycle_counter;
		logic [LINE_W-1:0]       current_line;
		logic                    prev_stat_cond;
	} timing_state_t;

endpackage

`default_nettype wire

// ===== sv/lcdlt_step.sv =====
// ----------------------------------------------------------------------------
// LCD line timing step
// Next-state and result logic for one transaction: counter update, mode
// decode, line compare, status edge detect and line advance.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdlt_step #(
	parameter int LINE_CYCLES   = 456,
	parameter int OAM_CYCLES    = 80,
	parameter int DRAW_CYCLES   = 172,
	parameter int VISIBLE_LINES = 144,
	parameter int LAST_LINE     = 153
) (
	input  lcdlt_pkg::timing_state_t state,
	input  lcdlt_pkg::in_t           item,
	output lcdlt_pkg::timing_state_t state_next,
	output lcdlt_pkg::out_t          result
);
	import lcdlt_pkg::*;

	localparam logic signed [CNT_W-1:0] LineCnt = CNT_W'(LINE_CYCLES);
	localparam logic signed [CNT_W-1:0] OamThr  = CNT_W'(LINE_CYCLES - OAM_CYCLES);
	localparam logic signed [CNT_W-1:0] DrawThr =
		CNT_W'(LINE_CYCLES - OAM_CYCLES - DRAW_CYCLES);
	localparam logic [LINE_W-1:0] VisLine  = LINE_W'(VISIBLE_LINES);
	localparam logic [LINE_W-1:0] LastLine = LINE_W'(LAST_LINE);

	logic signed [CNT_W-1:0] cnt_sub;
	mode_t                   mode;
	logic                    match;
	logic                    cond;
	logic [LINE_W-1:0]       line_inc;

	always_comb begin
		cnt_sub  = state.cycle_counter - $signed({{(CNT_W-8){1'b0}}, item.cycles});
		line_inc = state.current_line + LINE_W'(1);

		if (state.current_line >= VisLine) begin
			mode = MODE_VBLANK;
		end else if (cnt_sub >= OamThr) begin
			mode = MODE_OAM;
		end else if (cnt_sub >= DrawThr) begin
			mode = MODE_DRAW;
		end else begin
			mode = MODE_HBLANK;
		end

		match = (state.current_line == item.lyc);
		cond  = (match && item.int_en_lyc) ||
			(mode == MODE_OAM && item.int_en_oam) ||
			(mode == MODE_HBLANK && item.int_en_hblank) ||
			(mode == MODE_VBLANK && item.int_en_vblank);

		state_next = state;
		result     = '0;

		if (!item.lcd_enable) begin
			// Display off: restart the frame, keep the status edge memory.
			state_next.cycle_counter = LineCnt;
			state_next.current_line  = '0;
			result.mode              = MODE_HBLANK;
		end else begin
			state_next.prev_stat_cond = cond;
			state_next.cycle_counter  = cnt_sub;
			result.mode               = mode;
			result.lyc_match          = match;
			result.stat_irq           = cond && !state.prev_stat_cond;
			if (cnt_sub <= 0) begin
				state_next.cycle_counter = cnt_sub + LineCnt;
				if (state.current_line < VisLine) begin
					result.render_req  = 1'b1;
					result.render_line = state.current_line;
				end
				if (state.current_line >= LastLine || state.current_line == '1) begin
					state_next.current_line = '0;
				end else begin
					state_next.current_line = line_inc;
					result.vblank_irq       = (line_inc == VisLine);
				end
			end
			result.line = state_next.current_line;
		end
	end

endmodule

`default_nettype wire

// ===== sv/lcd_line_timing_and_status.sv =====
// ----------------------------------------------------------------------------
// LCD line timing and status
// Tracks the cycle position within a display line and the line number,
// and reports mode, line match and status, vblank and render events.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one timing update per transaction: cycles elapsed,
// display enable, line compare value and four status interrupt enables. Each
// accepted transaction produces exactly one result transaction on the output
// channel with the mode, the new line and the event pulses.
// The result is in the output register on the edge that accepts the input.
// Throughput is one transaction per cycle while the output is taken; the counter,
// line and edge memory update in a single pass of the step logic.
// The output register is the only buffer. While a result waits and out_ready
// is low, in_ready is low and the timing state holds; when the result is
// taken in the same cycle a new input may be accepted.
// Reset sets the cycle counter to LINE_CYCLES, the line to 0, clears the
// status edge memory and empties the output register. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_line_timing_and_status #(
	parameter int LINE_CYCLES   = 456,
	parameter int OAM_CYCLES    = 80,
	parameter int DRAW_CYCLES   = 172,
	parameter int VISIBLE_LINES = 144,
	parameter int LAST_LINE     = 153
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  lcdlt_pkg::in_t  in_data,
	output logic            out_valid,
	input  wire             out_ready,
	output lcdlt_pkg::out_t out_data
);
	import lcdlt_pkg::*;

	timing_state_t state_q;
	timing_state_t state_next;
	out_t          result;
	out_t          out_data_q;
	logic          out_valid_q;
	logic          accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	lcdlt_step #(
		.LINE_CYCLES  (LINE_CYCLES),
		.OAM_CYCLES   (OAM_CYCLES),
		.DRAW_CYCLES  (DRAW_CYCLES),
		.VISIBLE_LINES(VISIBLE_LINES),
		.LAST_LINE    (LAST_LINE)
	) u_step (
		.state     (state_q),
		.item      (in_data),
		.state_next(state_next),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cycle_counter  <= CNT_W'(LINE_CYCLES);
			state_q.current_line   <= '0;
			state_q.prev_stat_cond <= 1'b0;
			out_valid_q            <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cycle_counter > 0 && state_q.cycle_counter <= CNT_W'(LINE_CYCLES))
		else $error("cycle counter out of range");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.current_line <= LINE_W'(LAST_LINE) || state_q.current_line == '0)
		else $error("line beyond last line");

	a_render_visible: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.render_req |->
		out_data_q.render_line < LINE_W'(VISIBLE_LINES))
		else $error("render request for a non-visible line");

	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.vblank_irq |->
		out_data_q.line == LINE_W'(VISIBLE_LINES) && out_data_q.mode != MODE_VBLANK)
		else $error("vblank pulse on wrong line");

	a_stall_state: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(state_q))
		else $error("timing state moved without a transaction");
`endif

endmodule

`default_nettype wire

// ===== tb/lcd_line_timing_and_status_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD line timing and status testbench
// Drives timing updates through the input channel and predicts the mode, line,
// line match and event pulses for each one. The predictions are checked against
// the output channel field by field, with random idling on both sides.
// ----------------------------------------------------------------------------

module lcd_line_timing_and_status_tb;

	import lcdlt_pkg::*;

	localparam int LINE_CYCLES   = 456;
	localparam int OAM_CYCLES    = 80;
	localparam int DRAW_CYCLES   = 172;
	localparam int VISIBLE_LINES = 144;
	localparam int LAST_LINE     = 153;

	localparam int MAX_SHOWN   = 10;
	localparam int HOLD_AT     = 600;
	localparam int HOLD_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	in_t  update_queue[$];
	out_t expected_timing[$];
	out_t want;

	// Predicted timing state.
	int   counter_model;
	int   line_model;
	logic stat_cond_model;

	int tx_gap;
	int rx_gap;
	int hold_left;
	int n_offered;
	int n_accepted;
	int n_results;
	int mismatches;
	int n_render;
	int n_vblank;
	int n_stat;
	int mode_seen[4];

	lcd_line_timing_and_status #(
		.LINE_CYCLES  (LINE_CYCLES),
		.OAM_CYCLES   (OAM_CYCLES),
		.DRAW_CYCLES  (DRAW_CYCLES),
		.VISIBLE_LINES(VISIBLE_LINES),
		.LAST_LINE    (LAST_LINE)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic out_t advance_line_timing(in_t u);
		out_t  r;
		mode_t m;
		logic  match;
		logic  cond;
		r = '0;
		counter_model = counter_model - int'(u.cycles);
		if (!u.lcd_enable) begin
			counter_model = LINE_CYCLES;
			line_model = 0;
			return r;
		end
		if (line_model >= VISIBLE_LINES)
			m = MODE_VBLANK;
		else if (counter_model >= LINE_CYCLES - OAM_CYCLES)
			m = MODE_OAM;
		else if (counter_model >= LINE_CYCLES - OAM_CYCLES - DRAW_CYCLES)
			m = MODE_DRAW;
		else
			m = MODE_HBLANK;
		match = (line_model == int'(u.lyc));
		cond = (match && u.int_en_lyc) ||
			(m == MODE_OAM && u.int_en_oam) ||
			(m == MODE_HBLANK && u.int_en_hblank) ||
			(m == MODE_VBLANK && u.int_en_vblank);
		r.stat_irq = cond && !stat_cond_model;
		stat_cond_model = cond;
		if (counter_model <= 0) begin
			counter_model = counter_model + LINE_CYCLES;
			if (line_model < VISIBLE_LINES) begin
				r.render_req = 1'b1;
				r.render_line = 8'(line_model);
			end
			// The last line wraps to 0 without a vblank pulse.
			if (line_model >= LAST_LINE) begin
				line_model = 0;
			end else begin
				line_model++;
				if (line_model == VISIBLE_LINES)
					r.vblank_irq = 1'b1;
			end
		end
		r.mode = m;
		r.line = 8'(line_model);
		r.lyc_match = match;
		return r;
	endfunction

	// Every few hundred transactions both sides run without idling for a stretch.
	function automatic int draw_idle(int n);
		if ((n % 250) >= 180)
			return 0;
		return $urandom_range(0, 4);
	endfunction

	task automatic offer(input logic [7:0] cyc, input logic en, input logic [7:0] cmp,
		input logic [3:0] ien);
		in_t u;
		while (update_queue.size() >= 4)
			@(negedge clk);
		u.cycles = cyc;
		u.lcd_enable = en;
		u.lyc = cmp;
		u.int_en_hblank = ien[3];
		u.int_en_vblank = ien[2];
		u.int_en_oam = ien[1];
		u.int_en_lyc = ien[0];
		update_queue.push_back(u);
		n_offered++;
	endtask

	// Long steps move through a whole frame quickly; the compare value often
	// tracks the current line so that line matches happen.
	task automatic offer_random(input bit long_steps, input bit allow_off);
		logic [7:0] cyc;
		logic [7:0] cmp;
		logic       en;
		if (long_steps)
			cyc = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(192, 255));
		else if ($urandom_range(0, 5) == 0)
			cyc = $urandom_range(0, 1) ? 8'd255 : 8'd0;
		else
			cyc = 8'($urandom_range(0, 255));
		en = allow_off ? ($urandom_range(0, 31) != 0) : 1'b1;
		if ($urandom_range(0, 9) < 4)
			cmp = 8'(line_model + $urandom_range(0, 1));
		else
			cmp = 8'($urandom);
		offer(cyc, en, cmp, 4'($urandom));
	endtask

	task automatic wait_drained;
		while (update_queue.size() > 0 || in_valid || expected_timing.size() > 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			tx_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_timing.push_back(advance_line_timing(in_data));
				n_accepted++;
				tx_gap = draw_idle(n_accepted);
			end
			if (!in_valid || in_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (update_queue.size() > 0) begin
					in_data <= update_queue.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap = 0;
			hold_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_timing.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("unexpected result transaction: %p", out_data);
				end else begin
					want = expected_timing.pop_front();
					if (out_data.mode !== want.mode || out_data.line !== want.line ||
						out_data.lyc_match !== want.lyc_match ||
						out_data.stat_irq !== want.stat_irq ||
						out_data.vblank_irq !== want.vblank_irq ||
						out_data.render_req !== want.render_req ||
						out_data.render_line !== want.render_line) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("result %0d mismatch: expected %p, got %p",
								n_results, want, out_data);
					end
				end
				n_results++;
				mode_seen[out_data.mode]++;
				n_render += out_data.render_req;
				n_vblank += out_data.vblank_irq;
				n_stat += out_data.stat_irq;
				rx_gap = draw_idle(n_results);
				// One long hold lets the output register fill and stall the input.
				if (n_results == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		counter_model = LINE_CYCLES;
		line_model = 0;
		stat_cond_model = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Mode boundaries within one line, exact zero and overshoot of the
		// counter, and the display switched off in the middle of a line.
		offer(8'd255, 1'b0, 8'hFF, 4'b1111);
		offer(8'd0,   1'b1, 8'd0,  4'b0001);
		offer(8'd80,  1'b1, 8'hFF, 4'b0010);
		offer(8'd1,   1'b1, 8'd0,  4'b0000);
		offer(8'd171, 1'b1, 8'd0,  4'b0001);
		offer(8'd1,   1'b1, 8'd5,  4'b1000);
		offer(8'd203, 1'b1, 8'd0,  4'b0000);
		offer(8'd0,   1'b1, 8'd1,  4'b1111);
		offer(8'd255, 1'b1, 8'd2,  4'b0000);
		offer(8'd255, 1'b1, 8'd1,  4'b0100);
		offer(8'd128, 1'b1, 8'd2,  4'b0100);
		offer(8'd17,  1'b0, 8'd2,  4'b1111);
		offer(8'd0,   1'b1, 8'd0,  4'b0001);
		offer(8'd255, 1'b1, 8'hFF, 4'b0000);
		offer(8'd255, 1'b1, 8'h80, 4'b1111);
		offer(8'hAA,  1'b1, 8'h55, 4'b1010);
		offer(8'h55,  1'b1, 8'hAA, 4'b0101);
		offer(8'd0,   1'b0, 8'd0,  4'b0000);
		offer(8'd255, 1'b0, 8'hFF, 4'b1111);

		// The sender pauses here until every result has come back.
		wait_drained();

		// At least one full frame with the display on: vblank and the wrap.
		repeat (400) offer_random(1'b1, 1'b0);
		wait_drained();

		repeat (450) offer_random(1'b0, 1'b1);
		wait_drained();
		repeat (5) @(negedge clk);

		$display("checked %0d results from %0d timing updates, %0d mismatches",
			n_results, n_offered, mismatches);
		$display("modes h/v/o/d %0d/%0d/%0d/%0d, %0d renders, %0d vblank, %0d status pulses",
			mode_seen[MODE_HBLANK], mode_seen[MODE_VBLANK], mode_seen[MODE_OAM],
			mode_seen[MODE_DRAW], n_render, n_vblank, n_stat);
		if (mismatches == 0 && expected_timing.size() == 0)
			$display("** lcd_line_timing_and_status: PASSED **");
		else
			$display("** lcd_line_timing_and_status: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_timing.size());
		$display("** lcd_line_timing_and_status: FAILED **");
		$finish;
	end

endmodule
